// ===== rtl/core/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// shared types and constants of the nec infrared frame decoder
// ----------------------------------------------------------------------------
package necir_pkg;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_EDGE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // receive phase codes, also reported as rx_state
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_RECV = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEADER_MIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEADER_MAX = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_MIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_MAX   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_MIN    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_MAX    = 3'd5;

  // configuration reset values in microseconds
  localparam logic [15:0] RST_LEADER_MIN = 16'd12000;
  localparam logic [15:0] RST_LEADER_MAX = 16'd16000;
  localparam logic [15:0] RST_ZERO_MIN   = 16'd500;
  localparam logic [15:0] RST_ZERO_MAX   = 16'd1600;
  localparam logic [15:0] RST_ONE_MIN    = 16'd1700;
  localparam logic [15:0] RST_ONE_MAX    = 16'd2800;

  localparam int unsigned FRAME_LEN = 32;
  localparam int unsigned POS_W     = 5;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] req;
    logic       leader_hit;
    logic       zero_hit;
    logic       one_hit;
  } cls_item_t;

  // one result item
  typedef struct packed {
    logic [POS_W-1:0] bits_received;
    logic [1:0]       rx_state;
    logic             frame_ready;
    logic             key_valid;
    logic [7:0]       key_code;
  } result_t;

endpackage

// ===== rtl/core/necir_front.sv =====
// ----------------------------------------------------------------------------
// necir_front
// holds the timing windows and classifies each incoming interval
// ----------------------------------------------------------------------------
module necir_front
  import necir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_data,
  input  logic [1:0]            req_type,
  input  logic [15:0]           elapsed_us,
  output cls_item_t             item
);

  logic [15:0] leader_min, leader_max;
  logic [15:0] zero_min, zero_max;
  logic [15:0] one_min, one_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_min <= RST_LEADER_MIN;
      leader_max <= RST_LEADER_MAX;
      zero_min   <= RST_ZERO_MIN;
      zero_max   <= RST_ZERO_MAX;
      one_min    <= RST_ONE_MIN;
      one_max    <= RST_ONE_MAX;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LEADER_MIN: leader_min <= cfg_data;
        CFG_LEADER_MAX: leader_max <= cfg_data;
        CFG_ZERO_MIN:   zero_min   <= cfg_data;
        CFG_ZERO_MAX:   zero_max   <= cfg_data;
        CFG_ONE_MIN:    one_min    <= cfg_data;
        CFG_ONE_MAX:    one_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // all bounds exclusive
  always_comb begin
    item.req        = req_type;
    item.leader_hit = (elapsed_us > leader_min) && (elapsed_us < leader_max);
    item.zero_hit   = (elapsed_us > zero_min) && (elapsed_us < zero_max);
    item.one_hit    = (elapsed_us > one_min) && (elapsed_us < one_max);
  end

endmodule

// ===== rtl/core/necir_queue.sv =====
// ----------------------------------------------------------------------------
// necir_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
module necir_queue
  import necir_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cls_item_t in_item,
  output logic      out_valid,
  input  logic      out_pop,
  output cls_item_t out_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cls_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/necir_back.sv =====
// ----------------------------------------------------------------------------
// necir_back
// receive state machine, frame register and registered result output
// ----------------------------------------------------------------------------
module necir_back
  import necir_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_pop,
  input  cls_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_result
);

  logic [1:0]           phase, phase_next;
  logic [POS_W-1:0]     pos, pos_next;
  logic [FRAME_LEN-1:0] frame, frame_next;
  logic                 ready_flag, ready_flag_next;
  logic [7:0]           key;
  logic                 key_ok;
  logic                 check_ok;

  assign in_pop   = in_valid && (!out_valid || out_ready);
  assign check_ok = (frame[23:16] == ~frame[31:24]) && (frame[7:0] == ~frame[15:8]);

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    frame_next      = frame;
    ready_flag_next = ready_flag;
    key             = '0;
    key_ok          = 1'b0;
    case (in_item.req)
      REQ_EDGE: begin
        if (phase == PH_WAIT) begin
          phase_next = in_item.leader_hit ? PH_RECV : PH_IDLE;
        end else if (phase == PH_RECV) begin
          if (in_item.zero_hit || in_item.one_hit) begin
            // zero window wins where both match
            frame_next[pos] = !in_item.zero_hit;
            if (pos == POS_LAST) begin
              pos_next        = '0;
              phase_next      = PH_IDLE;
              ready_flag_next = 1'b1;
            end else begin
              pos_next = pos + 1'b1;
            end
          end else begin
            // bad bit interval aborts reception
            pos_next   = '0;
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next = PH_WAIT;
        end
      end
      REQ_TIMEOUT: begin
        phase_next = PH_IDLE;
        pos_next   = '0;
      end
      REQ_READ: begin
        if (ready_flag) begin
          if (check_ok) begin
            key    = frame[23:16];
            key_ok = 1'b1;
          end
          ready_flag_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      pos        <= '0;
      frame      <= '0;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_pop) begin
        phase      <= phase_next;
        pos        <= pos_next;
        frame      <= frame_next;
        ready_flag <= ready_flag_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      out_result.key_code      <= key;
      out_result.key_valid     <= key_ok;
      out_result.frame_ready   <= ready_flag_next;
      out_result.rx_state      <= phase_next;
      out_result.bits_received <= pos_next;
    end
  end

endmodule

// ===== rtl/core/nec_ir_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top
// nec infrared remote frame decoder with stream ports
// ----------------------------------------------------------------------------
// Each input transfer is one event: a falling edge with the microseconds since
// the previous edge, an interval timer timeout, or a read of the key code.
// Every input transfer yields exactly one output transfer carrying the key
// code (command byte when address and command complement checks pass, else
// zero), a key valid flag, the frame ready flag, the receive phase and the
// index of the next bit. The block takes one transfer per clock while the
// queue has room: the front compares the interval against the three timing
// windows in the cycle of acceptance, a two-entry queue holds the classified
// event, and the back updates the receive state and loads the output register
// when it pops the event. Output valid rises when the back loads the output
// register; either side may stall without loss. Timing windows are written
// through the cfg port; the user must write them only while no event is in
// flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top
  import necir_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]           cfg_data,
  // event stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] elapsed_us
  input  logic [1:0]            s_tuser,   // [1:0] req_type
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // [7:0] key_code, [8] key_valid,
                                           // [9] frame_ready, [11:10] rx_state,
                                           // [16:12] bits_received, [23:17] zero
);

  cls_item_t front_item;
  cls_item_t head_item;
  logic      head_valid;
  logic      head_pop;
  result_t   result;

  // front: timing windows and interval classification
  necir_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .req_type   (s_tuser),
    .elapsed_us (s_tdata),
    .item       (front_item)
  );

  // decoupling queue, its not-full flag is the input ready
  necir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (head_valid),
    .out_pop   (head_pop),
    .out_item  (head_item)
  );

  // back: receive state machine and output register
  necir_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (head_valid),
    .in_pop     (head_pop),
    .in_item    (head_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {7'd0, result};

  // an accepted event is queued by the next edge
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> head_valid)
    else $error("accepted event missing from queue");

  // a partial bit count only exists while receiving
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.bits_received != '0) |-> (result.rx_state == PH_RECV))
    else $error("bit count set outside reception");

  // a checked read always consumes the ready frame
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.key_valid) |-> !result.frame_ready)
    else $error("frame still ready after valid read");

  // the back never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== bench/tb_nec_ir_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder_top
// self-checking bench for the nec infrared frame decoder
// ----------------------------------------------------------------------------
// Events are streamed in as edges, timeouts, reads and the unused request
// kind. Each accepted transfer is run through a local decoder model, and the
// status it predicts is queued. Every result transfer is compared field by
// field with the oldest queued status. The run walks through several timing
// window settings: reset values, a shifted set, wide windows at the extremes,
// overlapping bit windows and windows that accept nothing. The sender idles in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_decoder_top;
  import necir_pkg::*;

  // request kind the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum int unsigned {
    FR_CLEAN, FR_NO_READ, FR_BAD_ADDR, FR_BAD_CMD, FR_RANDOM, FR_BAD_BIT, FR_TIMEOUT
  } frame_kind_t;

  typedef enum int unsigned {PACE_OPEN, PACE_RANDOM, PACE_PATTERN, PACE_STALLS} rx_pace_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [15:0]           cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // [15:0] elapsed_us
  logic [1:0]            s_tuser;   // [1:0] req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // [7:0] key_code, [8] key_valid, [9] frame_ready,
                                    // [11:10] rx_state, [16:12] bits_received

  nec_ir_frame_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // local copy of the decoder state and its timing windows
  logic [1:0]  rx_phase      = PH_IDLE;
  logic [4:0]  bit_pos       = '0;
  logic [31:0] frame_word    = '0;
  logic        frame_pending = 1'b0;
  logic [15:0] win_bound [0:5];

  // status words predicted for accepted transfers, oldest first
  result_t predicted_status_q [$];

  int unsigned fault_count  = 0;
  int unsigned results_seen = 0;

  // sender pacing: bursts of transfers separated by idle gaps
  int unsigned burst_left  = 0;
  bit          steady_send = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ------------------------------------------------------------------
  // decoder model
  // ------------------------------------------------------------------

  // all window bounds are exclusive
  function automatic bit in_window(input logic [15:0] t, input logic [15:0] lo,
                                   input logic [15:0] hi);
    return (t > lo) && (t < hi);
  endfunction

  task automatic decode_event(input logic [1:0] req, input logic [15:0] t,
                              output result_t status);
    bit stored;
    status = '0;
    stored = 1'b1;
    case (req)
      REQ_EDGE: begin
        if (rx_phase == PH_WAIT) begin
          // leader check; bit position is left alone either way
          rx_phase = in_window(t, win_bound[CFG_LEADER_MIN], win_bound[CFG_LEADER_MAX])
                     ? PH_RECV : PH_IDLE;
        end else if (rx_phase == PH_RECV) begin
          // zero class wins where the two bit windows overlap
          if (in_window(t, win_bound[CFG_ZERO_MIN], win_bound[CFG_ZERO_MAX])) begin
            frame_word[bit_pos] = 1'b0;
          end else if (in_window(t, win_bound[CFG_ONE_MIN], win_bound[CFG_ONE_MAX])) begin
            frame_word[bit_pos] = 1'b1;
          end else begin
            // bad interval aborts, stored bits stay
            stored   = 1'b0;
            bit_pos  = '0;
            rx_phase = PH_IDLE;
          end
          if (stored) begin
            if (bit_pos == POS_LAST) begin
              bit_pos       = '0;
              rx_phase      = PH_IDLE;
              frame_pending = 1'b1;
            end else begin
              bit_pos = bit_pos + 5'd1;
            end
          end
        end else begin
          // idle, and the phase that cannot arise, arm on any edge
          rx_phase = PH_WAIT;
        end
      end
      REQ_TIMEOUT: begin
        rx_phase = PH_IDLE;
        bit_pos  = '0;
      end
      REQ_READ: begin
        if (frame_pending) begin
          if (frame_word[23:16] == ~frame_word[31:24] && frame_word[7:0] == ~frame_word[15:8])
          begin
            status.key_code  = frame_word[23:16];
            status.key_valid = 1'b1;
          end
          frame_pending = 1'b0;
        end
      end
      default: begin
      end
    endcase
    status.frame_ready   = frame_pending;
    status.rx_state      = rx_phase;
    status.bits_received = bit_pos;
  endtask

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // one transfer on the event stream; the model runs at acceptance
  task automatic send_event(input logic [1:0] req, input logic [15:0] t);
    result_t status;
    if (!steady_send && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    decode_event(req, t, status);
    predicted_status_q.push_back(status);
  endtask

  // drop valid and let every pending result come out
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (predicted_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    win_bound[idx] = val;
  endtask

  task automatic set_windows(input logic [15:0] ldr_lo, input logic [15:0] ldr_hi,
                             input logic [15:0] zro_lo, input logic [15:0] zro_hi,
                             input logic [15:0] one_lo, input logic [15:0] one_hi);
    write_reg(CFG_LEADER_MIN, ldr_lo);
    write_reg(CFG_LEADER_MAX, ldr_hi);
    write_reg(CFG_ZERO_MIN, zro_lo);
    write_reg(CFG_ZERO_MAX, zro_hi);
    write_reg(CFG_ONE_MIN, one_lo);
    write_reg(CFG_ONE_MAX, one_hi);
    cfg_we <= 1'b0;
  endtask

  // strictly inside a window, with the edge values now and then
  function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo + 16'd1;
    if (r == 1) return hi - 16'd1;
    return 16'($urandom_range(int'(hi) - 1, int'(lo) + 1));
  endfunction

  // interval that fits neither bit window, if one can be found
  function automatic logic [15:0] stray_interval();
    logic [15:0] cand;
    cand = 16'($urandom);
    for (int k = 0; k < 24; k++) begin
      if (!in_window(cand, win_bound[CFG_ZERO_MIN], win_bound[CFG_ZERO_MAX]) &&
          !in_window(cand, win_bound[CFG_ONE_MIN], win_bound[CFG_ONE_MAX]))
        return cand;
      case (k % 4)
        0:       cand = 16'($urandom);
        1:       cand = win_bound[CFG_ZERO_MIN];
        2:       cand = win_bound[CFG_ONE_MAX];
        default: cand = 16'hFFFF;
      endcase
    end
    return cand;
  endfunction

  // arm, leader, 32 bits lsb first, then usually a read
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] word;
    int          cut;
    addr = 8'($urandom);
    cmd  = 8'($urandom);
    word = {~cmd, cmd, ~addr, addr};
    case (kind)
      FR_BAD_ADDR: word[8 + $urandom_range(0, 7)]  = ~word[8 + $urandom_range(0, 7)];
      FR_BAD_CMD:  word[24 + $urandom_range(0, 7)] = ~word[24 + $urandom_range(0, 7)];
      FR_RANDOM:   word = $urandom;
      default: begin
      end
    endcase
    // a corrupted complement may be flipped back by chance; the model decides
    cut = (kind == FR_BAD_BIT || kind == FR_TIMEOUT) ? $urandom_range(0, 31) : 32;
    if (rx_phase != PH_IDLE) send_event(REQ_TIMEOUT, 16'($urandom));
    send_event(REQ_EDGE, 16'($urandom));
    send_event(REQ_EDGE, pick_in(win_bound[CFG_LEADER_MIN], win_bound[CFG_LEADER_MAX]));
    for (int i = 0; i < 32; i++) begin
      if (i == cut) begin
        if (kind == FR_BAD_BIT) send_event(REQ_EDGE, stray_interval());
        else send_event(REQ_TIMEOUT, 16'($urandom));
        break;
      end
      if (word[i]) send_event(REQ_EDGE, pick_in(win_bound[CFG_ONE_MIN], win_bound[CFG_ONE_MAX]));
      else send_event(REQ_EDGE, pick_in(win_bound[CFG_ZERO_MIN], win_bound[CFG_ZERO_MAX]));
    end
    // skipping the read lets the next frame land on a pending one
    if (kind != FR_NO_READ) send_event(REQ_READ, 16'($urandom));
  endtask

  task automatic run_frames(input int unsigned count);
    frame_kind_t kind;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 11))
        0:       kind = FR_RANDOM;
        1:       kind = FR_BAD_ADDR;
        2:       kind = FR_BAD_CMD;
        3:       kind = FR_BAD_BIT;
        4:       kind = FR_TIMEOUT;
        5:       kind = FR_NO_READ;
        default: kind = FR_CLEAN;
      endcase
      // some frames go through with no sender gaps at all
      steady_send = ($urandom_range(0, 3) == 0);
      send_frame(kind);
    end
    steady_send = 1'b0;
  endtask

  // loose mix of every request kind with random, extreme and near-edge intervals
  task automatic run_noise(input int unsigned count);
    logic [1:0]  req;
    logic [15:0] t;
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      if (r < 5) req = REQ_EDGE;
      else if (r < 7) req = REQ_TIMEOUT;
      else if (r < 9) req = REQ_READ;
      else req = REQ_UNUSED;
      case ($urandom_range(0, 3))
        0:       t = 16'($urandom);
        1:       t = 16'(win_bound[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
        2:       t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: t = 16'($urandom);
      endcase
      send_event(req, t);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset windows: boundaries, every request kind, abort and timeout paths
  task automatic test_directed_reset_windows();
    send_event(REQ_READ, 16'h0000);     // read with nothing pending
    send_event(REQ_UNUSED, 16'hFFFF);   // ignored kind
    send_event(REQ_TIMEOUT, 16'h0000);
    send_event(REQ_EDGE, 16'h0000);     // arm
    send_event(REQ_EDGE, 16'd12000);    // leader on lower bound, rejected
    send_event(REQ_EDGE, 16'hFFFF);     // arm
    send_event(REQ_EDGE, 16'd16000);    // leader on upper bound, rejected
    send_event(REQ_EDGE, 16'd1);
    send_event(REQ_EDGE, 16'd12001);    // leader just inside
    send_event(REQ_EDGE, 16'd500);      // zero lower bound, bad bit
    send_event(REQ_EDGE, 16'h0000);
    send_event(REQ_EDGE, 16'd15999);
    send_event(REQ_EDGE, 16'd501);      // zero bit
    send_event(REQ_EDGE, 16'd1599);     // zero bit
    send_event(REQ_EDGE, 16'd1701);     // one bit
    send_event(REQ_EDGE, 16'd2799);     // one bit
    send_event(REQ_EDGE, 16'd1600);     // gap between the bit windows, bad bit
    send_event(REQ_EDGE, 16'hA5A5);
    send_event(REQ_EDGE, 16'd13000);
    send_event(REQ_EDGE, 16'd2000);     // one bit
    send_event(REQ_TIMEOUT, 16'h5A5A);  // mid-frame timeout
    send_event(REQ_READ, 16'hFFFF);
    send_event(REQ_UNUSED, 16'h0000);
    drain_pipeline();
  endtask

  // well-formed frames, first ones steered through read outcomes
  task automatic test_frames_reset_windows();
    send_frame(FR_CLEAN);
    send_frame(FR_BAD_CMD);     // read with a failed check
    send_frame(FR_NO_READ);
    send_frame(FR_CLEAN);       // lands while a frame is still pending
    run_frames(2);
    run_noise(20);
    drain_pipeline();
  endtask

  task automatic test_shifted_windows();
    set_windows(16'd8000, 16'd10000, 16'd200, 16'd700, 16'd900, 16'd1400);
    run_frames(4);
    run_noise(20);
    drain_pipeline();
  endtask

  // register extremes: leader takes almost anything, narrow zero window
  task automatic test_wide_windows();
    set_windows(16'd0, 16'hFFFF, 16'd0, 16'd40, 16'd40, 16'hFFFF);
    run_frames(2);
    run_noise(20);
    drain_pipeline();
  endtask

  // zero and one windows overlap, zero must win
  task automatic test_overlapping_windows();
    set_windows(16'd3000, 16'd5000, 16'd400, 16'd2000, 16'd1000, 16'd3000);
    send_event(REQ_EDGE, 16'h0000);
    send_event(REQ_EDGE, 16'd4000);
    send_event(REQ_EDGE, 16'd1500);     // in both windows
    send_event(REQ_EDGE, 16'd2500);     // one window only
    send_event(REQ_EDGE, 16'd1000);     // zero window only
    send_event(REQ_EDGE, 16'd3000);     // neither, bad bit
    run_frames(2);
    run_noise(10);
    drain_pipeline();
  endtask

  // inverted and empty windows: nothing can start or store
  task automatic test_closed_windows();
    set_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'd1);
    run_noise(30);
    drain_pipeline();
  endtask

  task automatic test_back_to_reset_windows();
    set_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                RST_ONE_MIN, RST_ONE_MAX);
    run_frames(2);
    run_noise(20);
    drain_pipeline();
  endtask

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------

  // receiver pacing switches among open, random, patterned and stalling modes
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    logic [7:0]  pattern;
    rx_pace_t    pace;
    m_tready   <= 1'b0;
    stall_left = 0;
    cyc        = 0;
    pattern    = 8'b1011_0110;
    pace       = PACE_OPEN;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 150 == 0) pace = rx_pace_t'($urandom_range(0, 3));
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        case (pace)
          PACE_OPEN:   m_tready <= 1'b1;
          PACE_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
          PACE_PATTERN: begin
            m_tready <= pattern[0];
            pattern  = {pattern[0], pattern[7:1]};
          end
          default: begin
            if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(4, 20);
              m_tready   <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[16:0]);
      if (predicted_status_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result %0d: tdata %h with nothing pending",
                   results_seen, m_tdata);
      end else begin
        want = predicted_status_q.pop_front();
        check_field("key_code", want.key_code, got.key_code);
        check_field("key_valid", want.key_valid, got.key_valid);
        check_field("frame_ready", want.frame_ready, got.frame_ready);
        check_field("rx_state", want.rx_state, got.rx_state);
        check_field("bits_received", want.bits_received, got.bits_received);
      end
      results_seen++;
    end
  end

  // ------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------

  initial begin
    win_bound[CFG_LEADER_MIN] = RST_LEADER_MIN;
    win_bound[CFG_LEADER_MAX] = RST_LEADER_MAX;
    win_bound[CFG_ZERO_MIN]   = RST_ZERO_MIN;
    win_bound[CFG_ZERO_MAX]   = RST_ZERO_MAX;
    win_bound[CFG_ONE_MIN]    = RST_ONE_MIN;
    win_bound[CFG_ONE_MAX]    = RST_ONE_MAX;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_addr <= CFG_LEADER_MIN;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_EDGE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_reset_windows();
    test_frames_reset_windows();
    test_shifted_windows();
    test_wide_windows();
    test_overlapping_windows();
    test_closed_windows();
    test_back_to_reset_windows();

    // room for any stray result after the last one due
    repeat (8) @(posedge clk);
    if (fault_count == 0 && predicted_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
